@@ hw/rtl/mrrc_pkg.sv @@
package mrrc_pkg;

    // Item kinds
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Direction codes
    localparam logic [1:0] DIR_STOP     = 2'd0;
    localparam logic [1:0] DIR_FORWARD  = 2'd1;
    localparam logic [1:0] DIR_BACKWARD = 2'd2;
    localparam logic [1:0] DIR_INVALID  = 2'd3;

    // Mode codes as driven on the result channel
    localparam logic [1:0] MODE_CODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_CODE_CHANGING = 2'd1;
    localparam logic [1:0] MODE_CODE_RUNNING  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_TIME = 2'd1;

    localparam logic [7:0] RAMP_STEP_RESET = 8'd1;
    localparam logic [7:0] DEAD_TIME_RESET = 8'd1;
    localparam logic [7:0] DUTY_MAX        = 8'd100;
    localparam logic [7:0] COUNT_MAX       = 8'd255;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'b001,
        MODE_CHANGING = 3'b010,
        MODE_RUNNING  = 3'b100
    } mode_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] duty;
        logic [1:0] direction;
    } cmd_item_t;

    typedef struct packed {
        logic [6:0] pwm_duty;
        logic       dir_level;
        logic [1:0] mode;
    } res_item_t;

    typedef struct packed {
        logic [7:0] ramp_step;
        logic [7:0] dead_time_ticks;
    } cfg_t;

endpackage

@@ hw/rtl/mrrc_ifs.sv @@
interface mrrc_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] duty;
    logic [1:0] direction;

    modport source (output valid, kind, duty, direction, input ready);
    modport sink   (input valid, kind, duty, direction, output ready);
endinterface

interface mrrc_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] pwm_duty;
    logic       dir_level;
    logic [1:0] mode;

    modport source (output valid, pwm_duty, dir_level, mode, input ready);
    modport sink   (input valid, pwm_duty, dir_level, mode, output ready);
endinterface

interface mrrc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/motor_ramp_reversal_controller_unit.sv @@
// Channel | Dir  | Beat contents
// --------+------+------------------------------------------------
// item    | in   | kind, duty, direction (command or update tick)
// result  | out  | pwm_duty, dir_level, mode (one per item)
// cfg     | in   | index, data (ramp_step = 0, dead_time_ticks = 1)
//
// One item per clock sustained while the result side is ready. An accepted item is
// held in the input register, then goes through the update logic into the result
// register, which drives result valid. The state registers update as the item
// leaves the input register, so the next item sees them in the following cycle.
// Reset clears the state to idle, speed zero, direction stop. A stalled result
// holds the input stage; cfg is always ready.
module motor_ramp_reversal_controller_unit (
    input  logic          clk,
    input  logic          rst_n,
    mrrc_item_if.sink     item,
    mrrc_result_if.source result,
    mrrc_cfg_if.sink      cfg
);
    import mrrc_pkg::*;

    logic      in_valid_reg, in_valid_next;
    cmd_item_t in_item_reg;
    logic      out_valid_reg, out_valid_next;
    res_item_t out_item_reg;

    logic      advance;
    logic      in_accept;
    cfg_t      cfg_cur;
    res_item_t core_res;

    // Move the held item on when the result register is free
    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign in_accept = item.valid && item.ready;

    assign cfg.ready = 1'b1;

    mrrc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_cur)
    );

    mrrc_ctrl_core u_ctrl_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_cur),
        .res     (core_res)
    );

    always_comb
    begin
        in_valid_next = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture the input beat, load the result beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.kind      <= item.kind;
            in_item_reg.duty      <= item.duty;
            in_item_reg.direction <= item.direction;
        end
        if (advance)
        begin
            out_item_reg <= core_res;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.pwm_duty  = out_item_reg.pwm_duty;
    assign result.dir_level = out_item_reg.dir_level;
    assign result.mode      = out_item_reg.mode;

    // Duty never leaves 0..100
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.pwm_duty <= DUTY_MAX[6:0]))
        else $error("pwm_duty above limit");

    // PWM stays off while the direction is changing
    a_dead_pwm_off: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.mode == MODE_CODE_CHANGING)) |-> (result.pwm_duty == 7'd0))
        else $error("pwm active during dead time");

    // A held item is never dropped while the result side stalls
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input item lost");

endmodule

@@ hw/rtl/mrrc_cfg_regs.sv @@
module mrrc_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [mrrc_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [7:0]                         wr_data,
    output mrrc_pkg::cfg_t                     cfg
);
    import mrrc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write beat; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_RAMP_STEP: cfg_next.ramp_step       = wr_data;
                REG_DEAD_TIME: cfg_next.dead_time_ticks = wr_data;
                default:       cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_step       <= RAMP_STEP_RESET;
            cfg_reg.dead_time_ticks <= DEAD_TIME_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/mrrc_ctrl_core.sv @@
module mrrc_ctrl_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  mrrc_pkg::cmd_item_t   item,
    input  mrrc_pkg::cfg_t        cfg,
    output mrrc_pkg::res_item_t   res
);
    import mrrc_pkg::*;

    mode_t      mode_reg,   mode_next;
    logic [7:0] cur_reg,    cur_next;
    logic [7:0] tgt_reg,    tgt_next;
    logic [1:0] cdir_reg,   cdir_next;
    logic [1:0] tdir_reg,   tdir_next;
    logic [7:0] dead_reg,   dead_next;
    logic       pin_reg,    pin_next;
    logic [6:0] pwm_reg,    pwm_next;

    logic [1:0] cmd_dir;
    logic [8:0] ramp_sum;
    logic [8:0] ramp_diff;
    logic [7:0] ramp_speed;
    logic [6:0] ramp_pwm;

    // Fold the unused direction code onto stop
    assign cmd_dir = (item.direction == DIR_INVALID) ? DIR_STOP : item.direction;

    // One ramp step toward the target, landing exactly on it
    assign ramp_sum  = {1'b0, cur_reg} + {1'b0, cfg.ramp_step};
    assign ramp_diff = {1'b0, cur_reg} - {1'b0, cfg.ramp_step};

    always_comb
    begin
        priority if (cur_reg < tgt_reg)
        begin
            ramp_speed = (ramp_sum > {1'b0, tgt_reg}) ? tgt_reg : ramp_sum[7:0];
        end
        else if (ramp_diff[8] || (ramp_diff[7:0] < tgt_reg))
        begin
            ramp_speed = tgt_reg;
        end
        else
        begin
            ramp_speed = ramp_diff[7:0];
        end
        ramp_pwm = (ramp_speed > DUTY_MAX) ? DUTY_MAX[6:0] : ramp_speed[6:0];
    end

    // Next state for the item at the head of the input stage
    always_comb
    begin
        mode_next = mode_reg;
        cur_next  = cur_reg;
        tgt_next  = tgt_reg;
        cdir_next = cdir_reg;
        tdir_next = tdir_reg;
        dead_next = dead_reg;
        pin_next  = pin_reg;
        pwm_next  = pwm_reg;
        if (item.kind == KIND_CMD)
        begin
            tgt_next  = item.duty;
            tdir_next = cmd_dir;
            if (cdir_reg != cmd_dir)
            begin
                if (mode_reg != MODE_CHANGING)
                begin
                    pwm_next  = '0;
                    cur_next  = '0;
                    mode_next = MODE_CHANGING;
                    dead_next = '0;
                end
            end
            else
            begin
                mode_next = MODE_RUNNING;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_CHANGING:
                begin
                    priority if (dead_reg >= cfg.dead_time_ticks)
                    begin
                        if (tdir_reg == DIR_FORWARD)
                            pin_next = 1'b1;
                        else if (tdir_reg == DIR_BACKWARD)
                            pin_next = 1'b0;
                        cdir_next = tdir_reg;
                        mode_next = MODE_RUNNING;
                    end
                    else if (dead_reg != COUNT_MAX)
                    begin
                        dead_next = dead_reg + 8'd1;
                    end
                    else
                    begin
                        dead_next = dead_reg;
                    end
                end
                MODE_RUNNING:
                begin
                    if (cur_reg != tgt_reg)
                    begin
                        cur_next = ramp_speed;
                        pwm_next = ramp_pwm;
                    end
                end
                MODE_IDLE:
                begin
                    mode_next = mode_reg;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Commit the state when the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cur_reg  <= '0;
            tgt_reg  <= '0;
            cdir_reg <= DIR_STOP;
            tdir_reg <= DIR_STOP;
            dead_reg <= '0;
            pin_reg  <= 1'b0;
            pwm_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            cur_reg  <= cur_next;
            tgt_reg  <= tgt_next;
            cdir_reg <= cdir_next;
            tdir_reg <= tdir_next;
            dead_reg <= dead_next;
            pin_reg  <= pin_next;
            pwm_reg  <= pwm_next;
        end
    end

    // Result reflects the state after the item
    always_comb
    begin
        res.pwm_duty  = pwm_next;
        res.dir_level = pin_next;
        unique case (mode_next)
            MODE_IDLE:     res.mode = MODE_CODE_IDLE;
            MODE_CHANGING: res.mode = MODE_CODE_CHANGING;
            MODE_RUNNING:  res.mode = MODE_CODE_RUNNING;
            default:       res.mode = MODE_CODE_IDLE;
        endcase
    end

endmodule
